// ===== hdl/sdp_df_pkg.sv =====
// Shared constants and types for the SDP response deframer.
// No dependencies; imported by sdp_response_deframer.
`timescale 1ns / 1ps
`default_nettype none

package sdp_df_pkg;

    localparam int unsigned POS_W   = 19;
    localparam int unsigned LEN_W   = POS_W + 1;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned LIST_W  = CNT_W + 2;
    localparam int unsigned TDATA_W = 56;
    localparam int unsigned TUSER_W = 2;

    localparam logic [POS_W-1:0] POS_MAX        = '1;
    localparam logic [LEN_W-1:0] MIN_RSP_LENGTH = LEN_W'(5);
    localparam logic [POS_W-1:0] SEARCH_START   = POS_W'(4);
    localparam logic [POS_W-1:0] ATTR_START     = POS_W'(2);
    localparam logic [7:0]       MAX_CONT_BYTES = 8'd16;

    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_ATTR   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_COUNT_ORD = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_BAD_CONT  = 3'd4
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/sdp_response_deframer.sv =====
// SDP response parameter deframer: splits counts, payload and continuation bytes.
// Depends on sdp_df_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                      Contents
// s_axis    in   s_axis_tvalid / s_axis_tready  one response byte, tlast on final byte
// m_axis    out  m_axis_tvalid / m_axis_tready  one result per byte, tlast = response done
// cfg       in   i_cfg_wr_en                    response kind (0 search, 1 attribute)
//
// One request in, one result out; a byte can be taken every cycle.
// The result is registered: decode of the byte position against the list bounds feeds
// the result register directly. The result register holds while m_axis_tready is
// low and the input stalls only when it is full and not being taken.
// Reset (synchronous, active low) clears position, counts, kind and result valid.
module sdp_response_deframer
    import sdp_df_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr_en,
    input  wire                 i_cfg_wr_data,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  wire                 s_axis_tlast,   // last_byte
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    // [7:0] payload_byte, [10:8] status, [26:11] total_count,
    // [42:27] current_count, [50:43] cont_length, [55:51] zero
    output logic [TDATA_W-1:0]  m_axis_tdata,
    output logic [TUSER_W-1:0]  m_axis_tuser,   // [0] payload_valid, [1] payload_is_cont
    output logic                m_axis_tlast    // response_done
);

    logic               r_kind;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [CNT_W-1:0]   r_first,  n_first;
    logic [CNT_W-1:0]   r_second, n_second;
    logic [7:0]         r_cont,   n_cont;

    logic               r_out_valid;
    logic [TDATA_W-1:0] r_tdata,  n_tdata;
    logic [TUSER_W-1:0] r_tuser,  n_tuser;
    logic               r_tlast;

    logic               w_acc;
    logic               w_search;
    logic [7:0]         w_b;
    logic [POS_W-1:0]   w_start;
    logic [POS_W-1:0]   w_cont_pos;
    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_need;
    logic [CNT_W-1:0]   w_first, w_second;
    logic [7:0]         w_cont;
    logic               w_pv, w_pc;
    t_status            w_status;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_search      = (r_kind == KIND_SEARCH);
    assign w_b           = s_axis_tdata;
    assign w_start       = w_search ? SEARCH_START : ATTR_START;

    // List end uses counts as stored before this byte.
    assign w_cont_pos = w_start + (w_search ? POS_W'({r_second, 2'b00}) : POS_W'(r_first));

    always_comb begin
        w_first  = r_first;
        w_second = r_second;
        w_cont   = r_cont;
        w_pv     = 1'b0;
        w_pc     = 1'b0;
        priority if (r_pos == POS_W'(0)) begin
            w_first = {w_b, 8'h00};
        end else if (r_pos == POS_W'(1)) begin
            w_first = r_first | {8'h00, w_b};
        end else if (w_search && r_pos == POS_W'(2)) begin
            w_second = {w_b, 8'h00};
        end else if (w_search && r_pos == POS_W'(3)) begin
            w_second = r_second | {8'h00, w_b};
        end else if (r_pos != POS_MAX) begin
            priority if (r_pos < w_cont_pos) begin
                w_pv = 1'b1;
            end else if (r_pos == w_cont_pos) begin
                w_cont = w_b;
            end else if (r_pos <= w_cont_pos + POS_W'(r_cont)) begin
                w_pv = 1'b1;
                w_pc = 1'b1;
            end else begin
                // beyond the declared continuation: dropped
                w_pv = 1'b0;
            end
        end else begin
            w_pv = 1'b0;
        end
    end

    // Final checks on the counts as updated by this byte.
    assign w_len  = LEN_W'(r_pos) + LEN_W'(1);
    assign w_need = LEN_W'(w_start) + LEN_W'(1)
                  + (w_search ? LEN_W'({w_second, 2'b00}) : LEN_W'(w_first));

    always_comb begin
        priority if (w_len < MIN_RSP_LENGTH) begin
            w_status = ST_TOO_SHORT;
        end else if (w_search && w_first < w_second) begin
            w_status = ST_COUNT_ORD;
        end else if (w_need > w_len) begin
            w_status = ST_TRUNCATED;
        end else if (w_cont > MAX_CONT_BYTES || w_need + LEN_W'(w_cont) != w_len) begin
            w_status = ST_BAD_CONT;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_tdata = '0;
        n_tuser = '0;
        if (w_pv) begin
            n_tdata[7:0] = w_b;
            n_tuser      = {w_pc, 1'b1};
        end
        if (s_axis_tlast) begin
            n_tdata[10:8]  = w_status;
            n_tdata[26:11] = w_first;
            n_tdata[42:27] = w_search ? w_second : CNT_W'(0);
            n_tdata[50:43] = w_cont;
        end
        if (s_axis_tlast) begin
            n_pos    = '0;
            n_first  = '0;
            n_second = '0;
            n_cont   = '0;
        end else begin
            n_pos    = (r_pos != POS_MAX) ? r_pos + POS_W'(1) : r_pos;
            n_first  = w_first;
            n_second = w_second;
            n_cont   = w_cont;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_SEARCH;
            r_pos       <= '0;
            r_first     <= '0;
            r_second    <= '0;
            r_cont      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_kind <= i_cfg_wr_data;
            end
            if (w_acc) begin
                r_pos       <= n_pos;
                r_first     <= n_first;
                r_second    <= n_second;
                r_cont      <= n_cont;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
            r_tlast <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;
    assign m_axis_tlast  = r_tlast;

`ifndef SYNTH
    a_cont_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tuser[1]) |-> r_tuser[0])
        else $error("continuation flag without payload valid");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tdata[10:8] != ST_OK) |-> r_tlast)
        else $error("status set on a non-final result");

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && s_axis_tlast) |=> (r_pos == '0 && r_first == '0 && r_cont == '0))
        else $error("state not cleared after final byte");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !s_axis_tlast && r_pos != POS_MAX) |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("byte position did not advance");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_out_valid && !m_axis_tready))
        else $error("input stalled while result register free");
`endif

endmodule

`default_nettype wire
